### hw/rtl/rtads_pkg.sv
// shared types and constants for the record table
package rtads_pkg;

  // default number of records in the table
  localparam int unsigned DepthDef = 32;

  // fixed field widths
  localparam int unsigned PosW    = 6;
  localparam int unsigned StatusW = 3;

  // operation codes
  typedef enum logic [1:0] {
    FuncAdd    = 2'd0,
    FuncDelete = 2'd1,
    FuncSearch = 2'd2,
    FuncList   = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StAdded    = 3'd0,
    StFull     = 3'd1,
    StDeleted  = 3'd2,
    StNoPos    = 3'd3,
    StEmpty    = 3'd4,
    StMatch    = 3'd5,
    StNotFound = 3'd6,
    StListed   = 3'd7
  } status_e;

  // one stored record
  typedef struct packed {
    logic [63:0] name_lo;
    logic [7:0]  name_hi;
    logic [63:0] sur_lo;
    logic [7:0]  sur_hi;
    logic [63:0] ph_lo;
    logic [31:0] ph_hi;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  // sequencer states
  typedef enum logic [3:0] {
    SIdle  = 4'b0001,
    SScan  = 4'b0010,
    SShift = 4'b0100,
    SFin   = 4'b1000
  } state_e;

endpackage

### hw/rtl/rtads_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module rtads_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/record_table_append_delete_search.sv
// record table top level: sequencer, result staging and output register
// add, full, empty, bad position: the result goes from the pending slot to the output register
// search, list: one read per cycle unless a match waits on a stalled output, beats go out as
//   records match, the last beat from the final state; no new request is taken until idle
// delete: the deleted record is the only beat, then one record shifted per cycle; no new
//   request is taken until the shift ends; reset zeroes the count, memory is not cleared
module record_table_append_delete_search
  import rtads_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [63:0]        name_low_i,
  input  logic [7:0]         name_high_i,
  input  logic [63:0]        surname_low_i,
  input  logic [7:0]         surname_high_i,
  input  logic [63:0]        phone_low_i,
  input  logic [31:0]        phone_high_i,
  input  logic [PosW-1:0]    position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [PosW-1:0]    record_position_o,
  output logic [63:0]        out_name_low_o,
  output logic [7:0]         out_name_high_o,
  output logic [63:0]        out_surname_low_o,
  output logic [7:0]         out_surname_high_o,
  output logic [63:0]        out_phone_low_o,
  output logic [31:0]        out_phone_high_o,
  output logic               last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pend_vld_q, pend_vld_d;
  logic          dvld_q, dvld_d;
  logic          out_vld_q, out_vld_d;
  logic          add_wr_q, add_wr_d;

  // payload state
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   cur_q, cur_d;
  logic [CW-1:0]   del_idx_q, del_idx_d;
  func_e           func_q, func_d;
  logic [63:0]     key_lo_q, key_lo_d;
  logic [7:0]      key_hi_q, key_hi_d;
  status_e         pend_st_q, pend_st_d;
  logic [PosW-1:0] pend_pos_q, pend_pos_d;
  rec_t            pend_rec_q, pend_rec_d;
  status_e         out_st_q, out_st_d;
  logic [PosW-1:0] out_pos_q, out_pos_d;
  rec_t            out_rec_q, out_rec_d;
  logic            out_last_q, out_last_d;

  // memory port signals
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  rec_t          ram_wdata, ram_rdata;

  logic          in_acc, out_free, consume, issue, match, first;
  logic [PosW-1:0] cnt_p, cur_p;
  rec_t          in_rec;

  rtads_ram #(
    .WIDTH (RecW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != SIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign cnt_p      = PosW'(cnt_q);
  assign cur_p      = PosW'(cur_q) + PosW'(1);

  assign in_rec = '{name_lo: name_low_i,    name_hi: name_high_i,
                    sur_lo:  surname_low_i, sur_hi:  surname_high_i,
                    ph_lo:   phone_low_i,   ph_hi:   phone_high_i};

  // name compare against the latched key, list takes every record
  assign match = (func_q == FuncList) ||
                 ((ram_rdata.name_lo == key_lo_q) && (ram_rdata.name_hi == key_hi_q));
  assign first = (cur_q == del_idx_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_vld_d = pend_vld_q;
    dvld_d     = dvld_q;
    add_wr_d   = add_wr_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    del_idx_d  = del_idx_q;
    func_d     = func_q;
    key_lo_d   = key_lo_q;
    key_hi_d   = key_hi_q;
    pend_st_d  = pend_st_q;
    pend_pos_d = pend_pos_q;
    pend_rec_d = pend_rec_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_st_d   = out_st_q;
    out_pos_d  = out_pos_q;
    out_rec_d  = out_rec_q;
    out_last_d = out_last_q;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[AW-1:0];
    ram_wdata  = pend_rec_q;
    ram_re     = 1'b0;
    ram_raddr  = idx_q[AW-1:0];
    consume    = 1'b0;
    issue      = 1'b0;

    case (state_q)
      SIdle: begin
        if (in_acc) begin
          func_d     = func_e'(func_i);
          key_lo_d   = name_low_i;
          key_hi_d   = name_high_i;
          pend_vld_d = 1'b1;
          pend_pos_d = '0;
          pend_rec_d = '0;
          add_wr_d   = 1'b0;
          dvld_d     = 1'b0;
          state_d    = SFin;
          case (func_e'(func_i))
            FuncAdd: begin
              if (cnt_q < CW'(DEPTH)) begin
                pend_st_d  = StAdded;
                pend_pos_d = cnt_p + PosW'(1);
                pend_rec_d = in_rec;
                add_wr_d   = 1'b1;
              end else begin
                pend_st_d = StFull;
              end
            end
            FuncDelete: begin
              if (cnt_q == '0) begin
                pend_st_d = StEmpty;
              end else if ((position_i == '0) || (position_i > cnt_p)) begin
                pend_st_d = StNoPos;
              end else begin
                idx_d     = CW'(position_i - PosW'(1));
                del_idx_d = CW'(position_i - PosW'(1));
                state_d   = SShift;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                pend_st_d = StEmpty;
              end else begin
                pend_vld_d = 1'b0;
                idx_d      = '0;
                state_d    = SScan;
              end
            end
          endcase
        end
      end

      // search, list: a hit waits in the pending slot; one read per cycle while it can drain
      SScan: begin
        consume = dvld_q && (!match || !pend_vld_q || out_free);
        issue   = (idx_q != cnt_q) && (!dvld_q || consume);
        if (consume && match) begin
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_st_d   = pend_st_q;
            out_pos_d  = pend_pos_q;
            out_rec_d  = pend_rec_q;
            out_last_d = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_st_d  = (func_q == FuncList) ? StListed : StMatch;
          pend_pos_d = cur_p;
          pend_rec_d = ram_rdata;
        end
        if (!dvld_q && (idx_q == cnt_q)) begin
          state_d = SFin;
        end
      end

      // delete: the first read record is the result, later ones move down one slot
      SShift: begin
        consume = dvld_q && (!first || out_free);
        issue   = (idx_q != cnt_q) && (!dvld_q || consume);
        if (consume && first) begin
          out_vld_d  = 1'b1;
          out_st_d   = StDeleted;
          out_pos_d  = cur_p;
          out_rec_d  = ram_rdata;
          out_last_d = 1'b1;
        end
        if (consume && !first) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(cur_q - CW'(1));
          ram_wdata = ram_rdata;
        end
        if (!dvld_q && (idx_q == cnt_q)) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = SIdle;
        end
      end

      // final beat of the item, and the append write
      SFin: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          if (pend_vld_q) begin
            out_st_d  = pend_st_q;
            out_pos_d = pend_pos_q;
            out_rec_d = pend_rec_q;
          end else begin
            out_st_d  = StNotFound;
            out_pos_d = '0;
            out_rec_d = '0;
          end
          if (add_wr_q) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
          pend_vld_d = 1'b0;
          add_wr_d   = 1'b0;
          state_d    = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase

    // read issue bookkeeping shared by scan and shift
    if (issue) begin
      ram_re = 1'b1;
      dvld_d = 1'b1;
      cur_d  = idx_q;
      idx_d  = idx_q + CW'(1);
    end else if (consume) begin
      dvld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      dvld_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      add_wr_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      dvld_q     <= dvld_d;
      out_vld_q  <= out_vld_d;
      add_wr_q   <= add_wr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cur_q      <= cur_d;
    del_idx_q  <= del_idx_d;
    func_q     <= func_d;
    key_lo_q   <= key_lo_d;
    key_hi_q   <= key_hi_d;
    pend_st_q  <= pend_st_d;
    pend_pos_q <= pend_pos_d;
    pend_rec_q <= pend_rec_d;
    out_st_q   <= out_st_d;
    out_pos_q  <= out_pos_d;
    out_rec_q  <= out_rec_d;
    out_last_q <= out_last_d;
  end

  // output beat
  assign out_valid_o        = out_vld_q;
  assign status_o           = out_st_q;
  assign record_position_o  = out_pos_q;
  assign out_name_low_o     = out_rec_q.name_lo;
  assign out_name_high_o    = out_rec_q.name_hi;
  assign out_surname_low_o  = out_rec_q.sur_lo;
  assign out_surname_high_o = out_rec_q.sur_hi;
  assign out_phone_low_o    = out_rec_q.ph_lo;
  assign out_phone_high_o   = out_rec_q.ph_hi;
  assign last_o             = out_last_q;

  // record count never passes the table size
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("record count beyond table size");

  // the shift never writes the slot it reads in the same cycle
  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("memory read and write collide");

  // leaving the final state always loads a last beat
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SFin) && out_free) |=> (out_vld_q && out_last_q && (state_q == SIdle)))
    else $error("final beat not loaded");

endmodule

### bench/record_table_sb_pkg.sv
// scoreboard for the record table: shadow table, expected result beats, error counting
package record_table_sb_pkg;
  import rtads_pkg::*;

  // one result beat as seen on the output channel
  typedef struct packed {
    status_e          status;
    logic [PosW-1:0]  pos;
    rec_t             rec;
    logic             last;
  } result_beat_t;

  class record_table_tracker;
    rec_t           slots [DepthDef];
    int unsigned    used;
    result_beat_t   pending [$];
    int unsigned    errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function void push_beat(status_e st, logic [PosW-1:0] pos, rec_t rec);
      result_beat_t b;
      b.status = st;
      b.pos    = pos;
      b.rec    = rec;
      b.last   = 1'b0;
      pending.push_back(b);
    endfunction

    // update the shadow table for one accepted request and queue its result beats
    function void note_request(func_e f, rec_t r, logic [PosW-1:0] p);
      int unsigned first;
      first = pending.size();
      case (f)
        FuncAdd: begin
          if (used < DepthDef) begin
            slots[used] = r;
            used++;
            push_beat(StAdded, PosW'(used), r);
          end else begin
            push_beat(StFull, '0, '0);
          end
        end
        FuncDelete: begin
          if (used == 0) begin
            push_beat(StEmpty, '0, '0);
          end else if (p == 0 || p > used) begin
            push_beat(StNoPos, '0, '0);
          end else begin
            push_beat(StDeleted, p, slots[int'(p) - 1]);
            // later records move down one place
            for (int i = int'(p) - 1; i + 1 < int'(used); i++) begin
              slots[i] = slots[i + 1];
            end
            used--;
          end
        end
        default: begin
          if (used == 0) begin
            push_beat(StEmpty, '0, '0);
          end else if (f == FuncSearch) begin
            for (int i = 0; i < int'(used); i++) begin
              if (slots[i].name_lo == r.name_lo && slots[i].name_hi == r.name_hi) begin
                push_beat(StMatch, PosW'(i + 1), slots[i]);
              end
            end
            if (pending.size() == first) begin
              push_beat(StNotFound, '0, '0);
            end
          end else begin
            for (int i = 0; i < int'(used); i++) begin
              push_beat(StListed, PosW'(i + 1), slots[i]);
            end
          end
        end
      endcase
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    // count every error, report only the first few
    function void note_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    // compare one output beat with the oldest expected beat
    function void check_beat(result_beat_t got);
      result_beat_t want;
      string        bad;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected result beat: status %0d pos %0d last %b",
                             got.status, got.pos, got.last));
        return;
      end
      want = pending.pop_front();
      bad  = "";
      if (got.status      !== want.status)      bad = {bad, " status"};
      if (got.pos         !== want.pos)         bad = {bad, " record_position"};
      if (got.rec.name_lo !== want.rec.name_lo) bad = {bad, " name_low"};
      if (got.rec.name_hi !== want.rec.name_hi) bad = {bad, " name_high"};
      if (got.rec.sur_lo  !== want.rec.sur_lo)  bad = {bad, " surname_low"};
      if (got.rec.sur_hi  !== want.rec.sur_hi)  bad = {bad, " surname_high"};
      if (got.rec.ph_lo   !== want.rec.ph_lo)   bad = {bad, " phone_low"};
      if (got.rec.ph_hi   !== want.rec.ph_hi)   bad = {bad, " phone_high"};
      if (got.last        !== want.last)        bad = {bad, " last"};
      if (bad != "") begin
        note_error($sformatf({"result mismatch on%s\n",
                              "  expected st %0d pos %0d name %h_%h sur %h_%h ph %h_%h last %b\n",
                              "  actual   st %0d pos %0d name %h_%h sur %h_%h ph %h_%h last %b"},
                             bad,
                             want.status, want.pos, want.rec.name_hi, want.rec.name_lo,
                             want.rec.sur_hi, want.rec.sur_lo, want.rec.ph_hi, want.rec.ph_lo,
                             want.last,
                             got.status, got.pos, got.rec.name_hi, got.rec.name_lo,
                             got.rec.sur_hi, got.rec.sur_lo, got.rec.ph_hi, got.rec.ph_lo,
                             got.last));
      end
    endfunction

    function void check_leftover();
      if (pending.size() != 0) begin
        note_error($sformatf("%0d expected result beats never arrived", pending.size()));
      end
    endfunction
  endclass

endpackage

### bench/record_table_append_delete_search_tb.sv
// testbench top for the record table: directed and random requests, scoreboard checking
module record_table_append_delete_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtads_pkg::*;
  import record_table_sb_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 80;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        func     = '0;
  logic [63:0]       name_low = '0;
  logic [7:0]        name_high = '0;
  logic [63:0]       surname_low = '0;
  logic [7:0]        surname_high = '0;
  logic [63:0]       phone_low = '0;
  logic [31:0]       phone_high = '0;
  logic [PosW-1:0]   position = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [PosW-1:0]   record_position;
  logic [63:0]       out_name_low;
  logic [7:0]        out_name_high;
  logic [63:0]       out_surname_low;
  logic [7:0]        out_surname_high;
  logic [63:0]       out_phone_low;
  logic [31:0]       out_phone_high;
  logic              last;

  bit                  quiet = 1'b0;
  int unsigned         cycle_count = 0;
  logic [63:0]         pool_lo [4];
  logic [7:0]          pool_hi [4];
  record_table_tracker tracker = new();

  record_table_append_delete_search DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .func_i             (func),
    .name_low_i         (name_low),
    .name_high_i        (name_high),
    .surname_low_i      (surname_low),
    .surname_high_i     (surname_high),
    .phone_low_i        (phone_low),
    .phone_high_i       (phone_high),
    .position_i         (position),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .status_o           (status),
    .record_position_o  (record_position),
    .out_name_low_o     (out_name_low),
    .out_name_high_o    (out_name_high),
    .out_surname_low_o  (out_surname_low),
    .out_surname_high_o (out_surname_high),
    .out_phone_low_o    (out_phone_low),
    .out_phone_high_o   (out_phone_high),
    .last_o             (last)
  );

  // clock
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("record_table_append_delete_search_tb: done, errors");
      $finish;
    end
  end

  // output monitor: check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_beat('{status: status_e'(status), pos: record_position,
                           rec: {out_name_low, out_name_high, out_surname_low,
                                 out_surname_high, out_phone_low, out_phone_high},
                           last: last});
    end
  end

  // receiver stall bursts, none in the quiet tail
  initial begin
    int unsigned n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 17);
        out_stall <= ($urandom_range(0, 2) == 0);
        // a burst ends early once the quiet tail starts
        repeat (n) begin
          if (!quiet) @(posedge clk);
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random record, name taken from the shared pool half of the time
  function automatic rec_t fresh_rec();
    rec_t        r;
    int unsigned k;
    r.name_lo = rand64();
    r.name_hi = 8'($urandom);
    r.sur_lo  = rand64();
    r.sur_hi  = 8'($urandom);
    r.ph_lo   = rand64();
    r.ph_hi   = $urandom;
    if ($urandom_range(0, 1) == 1) begin
      k = $urandom_range(0, 3);
      r.name_lo = pool_lo[k];
      r.name_hi = pool_hi[k];
    end
    return r;
  endfunction

  function automatic func_e pick_func(int unsigned wa, int unsigned wd, int unsigned ws,
                                      int unsigned wl);
    int unsigned r;
    r = $urandom_range(0, wa + wd + ws + wl - 1);
    if (r < wa) return FuncAdd;
    if (r < wa + wd) return FuncDelete;
    if (r < wa + wd + ws) return FuncSearch;
    return FuncList;
  endfunction

  // present one request beat and hold it until accepted
  task automatic send_item(input func_e f, input rec_t r, input logic [PosW-1:0] p);
    in_valid     <= 1'b1;
    func         <= f;
    name_low     <= r.name_lo;
    name_high    <= r.name_hi;
    surname_low  <= r.sur_lo;
    surname_high <= r.sur_hi;
    phone_low    <= r.ph_lo;
    phone_high   <= r.ph_hi;
    position     <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(f, r, p);
  endtask

  task automatic idle_for(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold the sender off until every expected beat has come
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  // one random request with the given operation weights
  task automatic random_item(input int unsigned wa, input int unsigned wd,
                             input int unsigned ws, input int unsigned wl);
    func_e           f;
    rec_t            r;
    logic [PosW-1:0] p;
    int unsigned     idx;
    f = pick_func(wa, wd, ws, wl);
    r = fresh_rec();
    // search keys mostly hit a stored name
    if (f == FuncSearch && tracker.used != 0 && $urandom_range(0, 2) != 0) begin
      idx = $urandom_range(0, tracker.used - 1);
      r.name_lo = tracker.slots[idx].name_lo;
      r.name_hi = tracker.slots[idx].name_hi;
    end
    // delete positions mostly valid
    if (tracker.used != 0 && $urandom_range(0, 4) != 0) begin
      p = PosW'($urandom_range(1, tracker.used));
    end else begin
      p = PosW'($urandom_range(0, 63));
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      idle_for($urandom_range(1, 17));
    end
    send_item(f, r, p);
  endtask

  // main sequence
  initial begin
    rec_t        r_zero;
    rec_t        r_ones;
    rec_t        r_a;
    rec_t        r_b;
    rec_t        r_miss;
    int unsigned full_hits;
    for (int k = 0; k < 4; k++) begin
      pool_lo[k] = rand64();
      pool_hi[k] = 8'($urandom);
    end
    r_zero = '0;
    r_ones = '1;
    r_a    = fresh_rec();
    r_b    = fresh_rec();
    r_b.name_lo = '1;
    r_b.name_hi = '1;
    r_miss = r_a;
    r_miss.name_hi = r_a.name_hi ^ 8'h01;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table cases
    send_item(FuncList, r_a, '0);
    send_item(FuncSearch, r_zero, '0);
    send_item(FuncDelete, r_zero, PosW'(1));
    // extremes of the record fields, two records sharing a name
    send_item(FuncAdd, r_zero, '0);
    send_item(FuncAdd, r_ones, '1);
    send_item(FuncAdd, r_a, '0);
    send_item(FuncAdd, r_b, '0);
    send_item(FuncSearch, r_ones, '0);
    send_item(FuncSearch, r_zero, '0);
    send_item(FuncSearch, r_miss, '0);
    send_item(FuncList, r_ones, '0);
    // bad positions: zero, one past the count, the top of the range
    send_item(FuncDelete, r_a, '0);
    send_item(FuncDelete, r_a, PosW'(5));
    send_item(FuncDelete, r_a, '1);
    // middle, last and first positions, then down to empty
    send_item(FuncDelete, r_a, PosW'(2));
    send_item(FuncList, r_a, '0);
    send_item(FuncDelete, r_a, PosW'(3));
    send_item(FuncDelete, r_a, PosW'(1));
    send_item(FuncList, r_a, '0);
    send_item(FuncDelete, r_a, PosW'(1));
    send_item(FuncDelete, r_a, PosW'(1));
    send_item(FuncSearch, r_a, '0);
    drain_all();

    // fill the table and keep pushing while it is full
    full_hits = 0;
    while (full_hits < 4) begin
      if (tracker.used == DepthDef) full_hits++;
      random_item(80, 4, 8, 8);
    end
    drain_all();

    // balanced mix
    repeat (10) random_item(30, 30, 25, 15);

    // delete heavy until the table is empty again
    while (tracker.used != 0) random_item(0, 95, 3, 2);
    drain_all();

    // tail with no idling on either side
    quiet = 1'b1;
    repeat (10) random_item(30, 30, 25, 15);

    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    tracker.check_leftover();
    if (tracker.errors == 0) begin
      $display("record_table_append_delete_search_tb: done, clean");
    end else begin
      $display("record_table_append_delete_search_tb: done, errors");
    end
    $finish;
  end

endmodule
